FILE: hw/rtl/string_literal_unescape_assert.svh
// ----------------------------------------------------------------------------
// String literal unescape: assertion macros
// Clocked property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef STRING_LITERAL_UNESCAPE_ASSERT_SVH
`define STRING_LITERAL_UNESCAPE_ASSERT_SVH

`ifndef SYNTHESIS

// check a property at every clock edge outside reset
`define SLU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// check that a condition is followed by a consequence in the same cycle
`define SLU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that a condition is followed by a consequence in the next cycle
`define SLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SLU_ASSERT(label, clk, rst_n, prop, msg)
`define SLU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/slu_pkg.sv
// ----------------------------------------------------------------------------
// String literal unescape: shared package
// Item types, status and mode codes, register map and the escape table.
// ----------------------------------------------------------------------------
package slu_pkg;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam int TAB_W   = 4;
    localparam int QDEPTH  = 2;

    localparam logic [PADDR_W-1:0] ADDR_TAB_SPACES = 2'd0;
    localparam logic [TAB_W-1:0]   TAB_RESET       = 4'd4;
    localparam logic [TAB_W-1:0]   TAB_MAX         = 4'd8;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOWT   = 8'h74;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        ST_BYTE     = 3'd0,
        ST_DONE     = 3'd1,
        ST_NOOPEN   = 3'd2,
        ST_BADCLOSE = 3'd3,
        ST_BADESC   = 3'd4,
        ST_BARE     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        M_WAIT = 3'd0,
        M_BODY = 3'd1,
        M_ESC  = 3'd2,
        M_SKIP = 3'd3,
        M_DROP = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       run_end;
    } t_out_item;

    // one queued command: count identical result words
    typedef struct packed {
        logic [7:0]       value;
        t_status          status;
        logic [TAB_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } t_esc;

    // fixed single-byte escapes; \t and \0 are handled by the caller
    function automatic t_esc f_escape(input logic [7:0] b);
        t_esc e;
        e.hit = 1'b1;
        case (b)
            8'h6E:     e.value = 8'd10;   // n
            8'h54:     e.value = 8'd9;    // T
            8'h61:     e.value = 8'd7;    // a
            8'h73:     e.value = 8'd32;   // s
            CH_BSLASH: e.value = 8'd92;
            8'h27:     e.value = 8'd39;   // '
            8'h62:     e.value = 8'd8;    // b
            CH_QUOTE:  e.value = 8'd34;
            CH_LBRACE: e.value = 8'd123;
            CH_RBRACE: e.value = 8'd125;
            default: begin
                e.hit   = 1'b0;
                e.value = CH_NUL;
            end
        endcase
        return e;
    endfunction

endpackage

FILE: hw/rtl/slu_front.sv
// ----------------------------------------------------------------------------
// String literal unescape: front end
// Tracks the literal mode and turns each input byte into a result command.
// ----------------------------------------------------------------------------
module slu_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  slu_pkg::t_in_item         i_data,
    input  logic                      i_full,
    input  logic [slu_pkg::TAB_W-1:0] i_tab_spaces,
    output logic                      o_push,
    output slu_pkg::t_cmd             o_cmd
);
    import slu_pkg::*;

    t_mode            r_mode;
    t_mode            n_mode;
    t_cmd             cmd;
    t_esc             esc;
    logic             accept;
    logic [7:0]       b;
    logic [TAB_W-1:0] tab_n;

    assign accept = i_valid && !i_full;
    assign b      = i_data.in_byte;
    assign esc    = f_escape(b);
    assign tab_n  = (i_tab_spaces > TAB_MAX) ? TAB_MAX : i_tab_spaces;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_WAIT;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        cmd.value    = CH_NUL;
        cmd.status   = ST_BYTE;
        cmd.count    = '0;
        if (i_data.first_byte) begin
            if (b != CH_QUOTE) begin
                cmd.status = ST_NOOPEN;
                cmd.count  = TAB_W'(1);
                n_mode     = i_data.last_byte ? M_WAIT : M_DROP;
            end else if (i_data.last_byte) begin
                // a lone quote never closes
                cmd.status = ST_BADCLOSE;
                cmd.count  = TAB_W'(1);
                n_mode     = M_WAIT;
            end else begin
                n_mode = M_BODY;
            end
        end else begin
            unique case (r_mode)
                M_BODY: begin
                    if (i_data.last_byte) begin
                        cmd.status = (b == CH_QUOTE) ? ST_DONE : ST_BADCLOSE;
                        cmd.count  = TAB_W'(1);
                        n_mode     = M_WAIT;
                    end else if (b == CH_BSLASH) begin
                        n_mode = M_ESC;
                    end else if (b == CH_QUOTE || b == CH_LBRACE || b == CH_RBRACE) begin
                        cmd.status = ST_BARE;
                        cmd.count  = TAB_W'(1);
                        n_mode     = M_DROP;
                    end else begin
                        cmd.value = b;
                        cmd.count = TAB_W'(1);
                    end
                end
                M_ESC: begin
                    if (i_data.last_byte) begin
                        // escape still open at the closing quote
                        cmd.status = ST_BADCLOSE;
                        cmd.count  = TAB_W'(1);
                        n_mode     = M_WAIT;
                    end else if (b == CH_ZERO) begin
                        cmd.count = TAB_W'(1);
                        n_mode    = M_SKIP;
                    end else if (b == CH_LOWT) begin
                        cmd.value = CH_SPACE;
                        cmd.count = tab_n;
                        n_mode    = M_BODY;
                    end else if (esc.hit) begin
                        cmd.value = esc.value;
                        cmd.count = TAB_W'(1);
                        n_mode    = M_BODY;
                    end else begin
                        cmd.status = ST_BADESC;
                        cmd.count  = TAB_W'(1);
                        n_mode     = M_DROP;
                    end
                end
                M_SKIP: begin
                    if (i_data.last_byte) begin
                        cmd.status = (b == CH_QUOTE) ? ST_DONE : ST_BADCLOSE;
                        cmd.count  = TAB_W'(1);
                        n_mode     = M_WAIT;
                    end
                end
                M_DROP: begin
                    if (i_data.last_byte) begin
                        n_mode = M_WAIT;
                    end
                end
                M_WAIT: begin
                    n_mode = M_WAIT;
                end
                default: begin
                    n_mode = M_WAIT;
                end
            endcase
        end
    end

    // a zero-length command (ignored byte, empty tab run) is not queued
    assign o_push = accept && (cmd.count != '0);
    assign o_cmd  = cmd;

endmodule

FILE: hw/rtl/slu_fifo.sv
// ----------------------------------------------------------------------------
// String literal unescape: command queue
// Short register queue between the front end and the result stage.
// ----------------------------------------------------------------------------
`include "string_literal_unescape_assert.svh"

module slu_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  slu_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output slu_pkg::t_cmd o_cmd
);
    import slu_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_cmd             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    assign o_full  = (r_count == CNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= f_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= f_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `SLU_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `SLU_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `SLU_ASSERT_IMPLY(a_no_empty_cmd, i_clk, i_rst_n, o_valid, o_cmd.count != '0, "empty command queued")

endmodule

FILE: hw/rtl/slu_back.sv
// ----------------------------------------------------------------------------
// String literal unescape: result stage
// Expands queued commands into result words behind an output register.
// ----------------------------------------------------------------------------
`include "string_literal_unescape_assert.svh"

module slu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  slu_pkg::t_cmd     i_head,
    output logic              o_pop,
    output logic              o_valid,
    output slu_pkg::t_out_item o_data,
    input  logic              i_stall
);
    import slu_pkg::*;

    logic [TAB_W-1:0] r_sent;
    logic             r_valid;
    t_out_item        r_data;
    logic             take;
    logic             last_word;

    assign take      = i_head_valid && (!r_valid || !i_stall);
    assign last_word = (r_sent + TAB_W'(1)) == i_head.count;
    assign o_pop     = take && last_word;
    assign o_valid   = r_valid;
    assign o_data    = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sent  <= '0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_sent  <= last_word ? '0 : r_sent + TAB_W'(1);
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data.out_byte <= i_head.value;
            r_data.status   <= i_head.status;
            r_data.run_end  <= last_word;
        end
    end

    `SLU_ASSERT_IMPLY(a_sent_in_range, i_clk, i_rst_n, i_head_valid, r_sent < i_head.count, "run counter past command length")
    `SLU_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, r_valid && !i_stall && !r_data.run_end, r_valid, "gap inside a result run")
    `SLU_ASSERT_IMPLY(a_idle_counter, i_clk, i_rst_n, !i_head_valid, r_sent == '0, "run counter busy with no command")

endmodule

FILE: hw/rtl/string_literal_unescape.sv
// ----------------------------------------------------------------------------
// String literal unescape
// Decodes the bytes of one quoted literal into result words.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the command queue is not full. Each
// byte gives at most one result word, except \t, which gives tab_spaces words
// (capped at 8) one after another; the words come from a two-entry queue of
// commands that the result stage drains one word a cycle while the output is
// not stalled, so a tab run stalls input only once that queue fills. A result
// word passes the queue register, then the output register, before it is shown.
// tab_spaces sits at byte address 0 of the APB port, reset value 4; the user must
// write it only while the block is idle, which the block itself does not enforce.
module string_literal_unescape (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  slu_pkg::t_in_item           i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output slu_pkg::t_out_item          o_out_data,
    input  logic                        i_out_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slu_pkg::PADDR_W-1:0] paddr,
    input  logic [slu_pkg::PDATA_W-1:0] pwdata,
    output logic [slu_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import slu_pkg::*;

    logic [TAB_W-1:0] r_tab_spaces;
    logic             full;
    logic             push;
    t_cmd             push_cmd;
    logic             head_valid;
    t_cmd             head_cmd;
    logic             pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_spaces <= TAB_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_TAB_SPACES) begin
            r_tab_spaces <= pwdata[TAB_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_TAB_SPACES) ? PDATA_W'(r_tab_spaces) : '0;

    assign o_in_stall = full;

    slu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_data       (i_in_data),
        .i_full       (full),
        .i_tab_spaces (r_tab_spaces),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    slu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    slu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .o_data       (o_out_data),
        .i_stall      (i_out_stall)
    );

endmodule

FILE: bench/slu_unescape_checker.sv
// ----------------------------------------------------------------------------
// String literal unescape: result checker
// Watches both word channels and the register port, predicts the result words
// of every accepted input word and compares them in order with the block.
// ----------------------------------------------------------------------------
module slu_unescape_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  slu_pkg::t_in_item           i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  slu_pkg::t_out_item          i_out_data,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [slu_pkg::PADDR_W-1:0] i_paddr,
    input  logic [slu_pkg::PDATA_W-1:0] i_pwdata,
    output int                          o_fail_count,
    output int                          o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import slu_pkg::*;

    // escape letters without a package name
    localparam logic [7:0] K_LOWN = 8'h6E;
    localparam logic [7:0] K_UPT  = 8'h54;
    localparam logic [7:0] K_LOWA = 8'h61;
    localparam logic [7:0] K_LOWS = 8'h73;
    localparam logic [7:0] K_APOS = 8'h27;
    localparam logic [7:0] K_LOWB = 8'h62;

    t_mode            mode_q;
    logic [TAB_W-1:0] tab_q;
    t_out_item        due_words[$];
    int               errs;

    function automatic t_out_item word_of(input logic [7:0] value, input t_status st);
        t_out_item w;
        w.out_byte = value;
        w.status   = st;
        w.run_end  = 1'b0;
        return w;
    endfunction

    task automatic decode_byte(input t_in_item w);
        t_out_item made[$];
        t_mode     nxt;
        int        n;
        nxt = mode_q;
        n   = (tab_q > TAB_MAX) ? int'(TAB_MAX) : int'(tab_q);
        if (w.first_byte) begin
            // a first word always restarts, whatever was in progress
            if (w.in_byte != CH_QUOTE) begin
                made.push_back(word_of(CH_NUL, ST_NOOPEN));
                nxt = w.last_byte ? M_WAIT : M_DROP;
            end else if (w.last_byte) begin
                made.push_back(word_of(CH_NUL, ST_BADCLOSE));
                nxt = M_WAIT;
            end else begin
                nxt = M_BODY;
            end
        end else begin
            case (mode_q)
                M_BODY: begin
                    if (w.last_byte) begin
                        made.push_back(word_of(CH_NUL,
                            (w.in_byte == CH_QUOTE) ? ST_DONE : ST_BADCLOSE));
                        nxt = M_WAIT;
                    end else if (w.in_byte == CH_BSLASH) begin
                        nxt = M_ESC;
                    end else if (w.in_byte == CH_QUOTE || w.in_byte == CH_LBRACE ||
                                 w.in_byte == CH_RBRACE) begin
                        made.push_back(word_of(CH_NUL, ST_BARE));
                        nxt = M_DROP;
                    end else begin
                        made.push_back(word_of(w.in_byte, ST_BYTE));
                    end
                end
                M_ESC: begin
                    if (w.last_byte) begin
                        made.push_back(word_of(CH_NUL, ST_BADCLOSE));
                        nxt = M_WAIT;
                    end else begin
                        nxt = M_BODY;
                        case (w.in_byte)
                            K_LOWN:    made.push_back(word_of(8'd10, ST_BYTE));
                            K_UPT:     made.push_back(word_of(8'd9, ST_BYTE));
                            K_LOWA:    made.push_back(word_of(8'd7, ST_BYTE));
                            K_LOWS:    made.push_back(word_of(8'd32, ST_BYTE));
                            CH_BSLASH: made.push_back(word_of(8'd92, ST_BYTE));
                            K_APOS:    made.push_back(word_of(8'd39, ST_BYTE));
                            K_LOWB:    made.push_back(word_of(8'd8, ST_BYTE));
                            CH_QUOTE:  made.push_back(word_of(8'd34, ST_BYTE));
                            CH_LBRACE: made.push_back(word_of(8'd123, ST_BYTE));
                            CH_RBRACE: made.push_back(word_of(8'd125, ST_BYTE));
                            CH_ZERO: begin
                                made.push_back(word_of(CH_NUL, ST_BYTE));
                                nxt = M_SKIP;
                            end
                            CH_LOWT: begin
                                for (int i = 0; i < n; i++)
                                    made.push_back(word_of(CH_SPACE, ST_BYTE));
                            end
                            default: begin
                                made.push_back(word_of(CH_NUL, ST_BADESC));
                                nxt = M_DROP;
                            end
                        endcase
                    end
                end
                M_SKIP: begin
                    if (w.last_byte) begin
                        made.push_back(word_of(CH_NUL,
                            (w.in_byte == CH_QUOTE) ? ST_DONE : ST_BADCLOSE));
                        nxt = M_WAIT;
                    end
                end
                M_DROP: begin
                    if (w.last_byte)
                        nxt = M_WAIT;
                end
                default: nxt = M_WAIT;
            endcase
        end
        if (made.size() > 0)
            made[made.size()-1].run_end = 1'b1;
        foreach (made[i])
            due_words.push_back(made[i]);
        mode_q = nxt;
    endtask

    task automatic compare_word(input t_out_item got);
        t_out_item want;
        if (due_words.size() == 0) begin
            $display("%0t: unexpected word: expected none, got byte %h status %0d end %b",
                     $time, got.out_byte, got.status, got.run_end);
            errs++;
        end else begin
            want = due_words.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $display("%0t: out_byte expected %h got %h", $time, want.out_byte,
                         got.out_byte);
                errs++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status,
                         got.status);
                errs++;
            end
            if (got.run_end !== want.run_end) begin
                $display("%0t: run_end expected %b got %b", $time, want.run_end,
                         got.run_end);
                errs++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q = M_WAIT;
            tab_q  = TAB_RESET;
            due_words.delete();
            errs   = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_TAB_SPACES)
                tab_q = i_pwdata[TAB_W-1:0];
            // compare before predicting: a word never leaves on the edge it enters
            if (i_out_valid && !i_out_stall)
                compare_word(i_out_data);
            if (i_in_valid && !i_in_stall)
                decode_byte(i_in_data);
        end
        o_fail_count <= errs;
        o_words_due  <= due_words.size();
    end

endmodule

FILE: bench/tb_string_literal_unescape.sv
// ----------------------------------------------------------------------------
// String literal unescape: testbench top
// Drives quoted literals, noise and tab width settings into the block under
// random idling on both channels, with one long result hold-off; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_string_literal_unescape;
    timeunit 1ns;
    timeprecision 1ps;

    import slu_pkg::*;

    localparam int PHASE_WORDS = 45;
    localparam int SETTLE      = 24;
    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLD_CYCLES = 150;

    // escape letters that decode to a fixed byte, plus the tab escape
    localparam logic [7:0] ESC_CHARS [0:10] = '{
        8'h6E, 8'h54, 8'h61, 8'h73, CH_BSLASH, 8'h27, 8'h62,
        CH_QUOTE, CH_LBRACE, CH_RBRACE, CH_LOWT
    };
    localparam logic [7:0] TAB_STEPS [0:4] = '{8'd0, 8'd8, 8'd15, 8'd1, 8'd0};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    t_in_item             i_in_data = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic                 i_out_stall = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic                 calm = 1'b0;
    logic                 burst = 1'b0;
    logic                 hold_req = 1'b0;
    int                   n_fail;
    int                   n_due;
    int                   lit_words = 0;

    string_literal_unescape i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    slu_unescape_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (n_fail),
        .o_words_due  (n_due)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req <= 1'b0;
                @(posedge i_clk);
            end else if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat (idle_len() + 1) @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input t_in_item w);
        int gap;
        gap = (burst || calm) ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_lit(input logic [7:0] txt[$]);
        t_in_item w;
        foreach (txt[k]) begin
            w.in_byte    = txt[k];
            w.first_byte = (k == 0);
            w.last_byte  = (k == txt.size() - 1);
            send_word(w);
        end
        lit_words += txt.size();
    endtask

    task automatic wait_idle();
        int spin;
        spin = 0;
        i_in_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (n_due != 0 && spin < DRAIN_LIMIT) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_tab(input logic [TAB_W-1:0] v);
        logic [PDATA_W-1:0] d;
        d = $urandom();
        d[TAB_W-1:0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TAB_SPACES;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random_literal();
        logic [7:0] txt[$];
        logic [7:0] b;
        int         len;
        int         r;
        txt.push_back(CH_QUOTE);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                do begin
                    b = (r < 30) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
                end while (b == CH_QUOTE || b == CH_BSLASH || b == CH_LBRACE ||
                           b == CH_RBRACE);
                txt.push_back(b);
            end else if (r < 82) begin
                txt.push_back(CH_BSLASH);
                txt.push_back(ESC_CHARS[$urandom_range(0, 10)]);
            end else if (r < 86) begin
                txt.push_back(CH_BSLASH);
                txt.push_back(CH_ZERO);
            end else if (r < 92) begin
                txt.push_back(CH_BSLASH);
                txt.push_back(8'($urandom_range(0, 255)));
            end else if (r < 95) begin
                case ($urandom_range(0, 2))
                    0:       txt.push_back(CH_QUOTE);
                    1:       txt.push_back(CH_LBRACE);
                    default: txt.push_back(CH_RBRACE);
                endcase
            end else begin
                txt.push_back(8'($urandom_range(0, 255)));
            end
        end
        r = $urandom_range(0, 99);
        if (r < 85) begin
            txt.push_back(CH_QUOTE);
        end else if (r < 92) begin
            // close with an escape still pending
            txt.push_back(CH_BSLASH);
            txt.push_back(CH_QUOTE);
        end else begin
            txt.push_back(8'($urandom_range(0, 255)));
        end
        send_lit(txt);
    endtask

    task automatic send_noise();
        t_in_item w;
        int       n;
        case ($urandom_range(0, 3))
            0: begin
                // stray words outside or inside a literal
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) begin
                    w.in_byte    = 8'($urandom_range(0, 255));
                    w.first_byte = 1'b0;
                    w.last_byte  = 1'($urandom_range(0, 1));
                    send_word(w);
                end
            end
            1: begin
                // abandon a literal: the next first word restarts
                n = $urandom_range(0, 4);
                w = '{in_byte: CH_QUOTE, first_byte: 1'b1, last_byte: 1'b0};
                send_word(w);
                for (int k = 0; k < n; k++) begin
                    w.in_byte    = ($urandom_range(0, 3) == 0) ? CH_BSLASH
                                                               : 8'($urandom_range(0, 255));
                    w.first_byte = 1'b0;
                    send_word(w);
                end
            end
            2: begin
                w = '{in_byte: CH_QUOTE, first_byte: 1'b1, last_byte: 1'b1};
                send_word(w);
            end
            default: begin
                n = $urandom_range(0, 3);
                w.in_byte    = 8'($urandom_range(0, 255));
                w.first_byte = 1'b1;
                w.last_byte  = (n == 0);
                send_word(w);
                for (int k = 0; k < n; k++) begin
                    w.in_byte    = 8'($urandom_range(0, 255));
                    w.first_byte = 1'b0;
                    w.last_byte  = (k == n - 1);
                    send_word(w);
                end
            end
        endcase
    endtask

    initial begin
        int phase_start;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed literals at the reset tab width
        send_lit('{CH_QUOTE, 8'hFF, 8'h00, CH_BSLASH, CH_LOWT, CH_QUOTE});
        send_lit('{CH_QUOTE, CH_BSLASH, CH_ZERO, 8'h78, CH_QUOTE});
        send_lit('{CH_QUOTE});
        send_lit('{8'h78, 8'h79});
        send_lit('{8'h78});
        send_word('{in_byte: 8'h41, first_byte: 1'b0, last_byte: 1'b0});
        send_lit('{CH_QUOTE, CH_LBRACE, CH_QUOTE});
        send_lit('{CH_QUOTE, CH_BSLASH, CH_QUOTE});
        send_lit('{CH_QUOTE, CH_BSLASH, 8'h71, CH_QUOTE});
        send_lit('{CH_QUOTE, 8'h25, 8'h78});

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_idle();
                write_tab((p == 5) ? 4'($urandom_range(0, 15)) : TAB_STEPS[p-1][TAB_W-1:0]);
            end
            if (p == 2) begin
                // fill the block: no input gaps while results are held off
                hold_req <= 1'b1;
                burst    <= 1'b1;
                repeat (4)
                    send_lit('{CH_QUOTE, CH_BSLASH, CH_LOWT, CH_BSLASH, CH_LOWT,
                               CH_BSLASH, CH_LOWT, CH_BSLASH, CH_LOWT, CH_QUOTE});
                burst <= 1'b0;
            end
            calm <= (p == 4);
            phase_start = lit_words;
            while (lit_words - phase_start < PHASE_WORDS) begin
                if ($urandom_range(0, 99) < 85)
                    send_random_literal();
                else
                    send_noise();
            end
        end
        calm <= 1'b0;

        wait_idle();
        if (n_fail == 0 && n_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
